/* sv/tcd_pkg.sv */
package tcd_pkg;

  localparam int TASKS     = 16;
  localparam int MASK_BITS = 16;
  localparam int INDEX_W   = 4;
  localparam int DELAY_W   = 16;
  localparam int MS_PER_S  = 1000;
  localparam int SUB_W     = $clog2(MS_PER_S);

  localparam logic [31:0] PERIOD_MS = 32'd2592000000;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_DELAY = 1'b1
  } kind_t;

  typedef struct packed {
    logic               tick;
    logic               add;
    logic [INDEX_W-1:0] task_index;
    logic [DELAY_W-1:0] delay_ms;
  } table_cmd_t;

endpackage

/* sv/tcd_delay_table.sv */
module tcd_delay_table import tcd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  table_cmd_t         cmd,
  output logic [DELAY_W-1:0] task_delay_left,
  output logic [MASK_BITS-1:0] ready_mask
);

  logic [DELAY_W-1:0]   entries      [TASKS];
  logic [DELAY_W-1:0]   entries_next [TASKS];
  logic [DELAY_W:0]     sum          [TASKS];
  logic [DELAY_W-1:0]   left_next;
  logic [MASK_BITS-1:0] mask_next;

  always_comb begin
    left_next = '0;
    mask_next = '0;
    for (int t = 0; t < TASKS; t++) begin
      sum[t] = {1'b0, entries[t]} + {1'b0, cmd.delay_ms};
      entries_next[t] = entries[t];
      if (cmd.tick && entries[t] != '0) begin
        entries_next[t] = entries[t] - DELAY_W'(1);
      end else if (cmd.add && t < MASK_BITS && cmd.task_index == INDEX_W'(t)) begin
        // saturate at full scale
        entries_next[t] = sum[t][DELAY_W] ? '1 : sum[t][DELAY_W-1:0];
      end
      if (t < MASK_BITS) begin
        if (entries_next[t] == '0) begin
          mask_next[t] = 1'b1;
        end
        if (cmd.task_index == INDEX_W'(t)) begin
          left_next = entries_next[t];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < TASKS; t++) begin
        entries[t] <= '0;
      end
    end else if (cmd.tick || cmd.add) begin
      entries <= entries_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick || cmd.add) begin
      task_delay_left <= left_next;
      ready_mask      <= mask_next;
    end
  end

endmodule

/* sv/tick_clock_with_task_delays.sv */
// channel  direction  handshake             payload
// in       into block in_valid / in_ready   kind, task_index, delay_ms
// out      from block out_valid / out_ready uptime_ms, period_wraps, uptime_seconds,
//                                           task_delay_left, ready_mask
// one item per cycle while the result is not stalled; the result appears in the cycle after its transfer
// the result registers hold the state after the item, so a new item is taken
// whenever the result slot is empty or being emptied in the same cycle
// a stalled result holds the input off, nothing else stalls
// synchronous reset clears the clock counters, the delay table and out_valid
module tick_clock_with_task_delays import tcd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 kind,
  input  logic [INDEX_W-1:0]   task_index,
  input  logic [DELAY_W-1:0]   delay_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          uptime_ms,
  output logic [31:0]          period_wraps,
  output logic [31:0]          uptime_seconds,
  output logic [DELAY_W-1:0]   task_delay_left,
  output logic [MASK_BITS-1:0] ready_mask
);

  logic             in_xfer;
  logic             tick;
  logic [31:0]      ms_counter;
  logic [31:0]      wrap_counter;
  logic [31:0]      seconds;
  logic [SUB_W-1:0] ms_in_second;
  table_cmd_t       cmd;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign tick     = in_xfer && kind == KIND_TICK;

  assign cmd.tick       = tick;
  assign cmd.add        = in_xfer && kind == KIND_DELAY;
  assign cmd.task_index = task_index;
  assign cmd.delay_ms   = delay_ms;

  tcd_delay_table u_table (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .task_delay_left (task_delay_left),
    .ready_mask      (ready_mask)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      ms_counter   <= '0;
      wrap_counter <= '0;
      seconds      <= '0;
      ms_in_second <= '0;
    end else begin
      if (in_xfer) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (tick) begin
        if (ms_counter >= PERIOD_MS - 32'd1) begin
          ms_counter   <= '0;
          wrap_counter <= wrap_counter + 32'd1;
        end else begin
          ms_counter <= ms_counter + 32'd1;
        end
        // seconds kept alongside; a period end always falls on a second boundary
        if (ms_in_second == SUB_W'(MS_PER_S - 1)) begin
          ms_in_second <= '0;
          seconds      <= seconds + 32'd1;
        end else begin
          ms_in_second <= ms_in_second + SUB_W'(1);
        end
      end
    end
  end

  assign uptime_ms      = ms_counter;
  assign period_wraps   = wrap_counter;
  assign uptime_seconds = seconds;

  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    tick && ms_counter != PERIOD_MS - 32'd1 |=> ms_counter == $past(ms_counter) + 32'd1)
    else $error("tick did not advance uptime");

  a_period_wrap: assert property (@(posedge clk) disable iff (rst)
    tick && ms_counter == PERIOD_MS - 32'd1
      |=> ms_counter == '0 && ms_in_second == '0 && wrap_counter == $past(wrap_counter) + 32'd1)
    else $error("period end not handled");

  a_delay_keeps_clock: assert property (@(posedge clk) disable iff (rst)
    in_xfer && kind == KIND_DELAY |=> $stable(ms_counter) && $stable(seconds))
    else $error("delay transfer moved the clock");

  a_counters_in_range: assert property (@(posedge clk) disable iff (rst)
    ms_counter < PERIOD_MS && ms_in_second < SUB_W'(MS_PER_S))
    else $error("clock counter out of range");

endmodule
